// File: rtl/alu_condition_code_unit_assert.svh
// Assertion macros used by the checker file of the ALU condition code unit.
`ifndef ALU_CONDITION_CODE_UNIT_ASSERT_SVH
`define ALU_CONDITION_CODE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ACC_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alu_condition_code_unit: assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define ACC_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alu_condition_code_unit: assertion failed");

`endif

// File: rtl/alu_cc_pkg.sv
// Types and constants of the ALU condition code unit.
`timescale 1ns / 1ps
`default_nettype none

package alu_cc_pkg;

	localparam int OP_W      = 5;
	localparam int DATA_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int COND_W    = 4;
	localparam int FSEL_W    = 2;
	localparam int CC_W      = 6;
	localparam int FLAGS_W   = 8;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	localparam int FLAG_C = 0;
	localparam int FLAG_V = 1;
	localparam int FLAG_Z = 2;
	localparam int FLAG_N = 3;
	localparam int FLAG_I = 4;
	localparam int FLAG_H = 5;

	localparam logic [1:0]        FLAG_PAD    = 2'b11;
	localparam logic [3:0]        BCD_DIGIT_MAX = 4'h9;
	localparam logic [BYTE_W-1:0] BCD_BYTE_MAX  = 8'h99;
	localparam logic [BYTE_W-1:0] DAA_LO_ADJ    = 8'h06;
	localparam logic [BYTE_W-1:0] DAA_HI_ADJ    = 8'h60;

	typedef enum logic [OP_W-1:0] {
		OP_ADD       = 5'd0,
		OP_ADC       = 5'd1,
		OP_SUB       = 5'd2,
		OP_SBC       = 5'd3,
		OP_INC       = 5'd4,
		OP_DEC       = 5'd5,
		OP_AND       = 5'd6,
		OP_OR        = 5'd7,
		OP_EOR       = 5'd8,
		OP_PASS      = 5'd9,
		OP_TST       = 5'd10,
		OP_CLR       = 5'd11,
		OP_COM       = 5'd12,
		OP_LSR       = 5'd13,
		OP_ASR       = 5'd14,
		OP_ASL       = 5'd15,
		OP_ROR       = 5'd16,
		OP_ROL       = 5'd17,
		OP_DAA       = 5'd18,
		OP_CMP16     = 5'd19,
		OP_PASS16    = 5'd20,
		OP_INC16     = 5'd21,
		OP_DEC16     = 5'd22,
		OP_FLAGWRITE = 5'd23,
		OP_TAP       = 5'd24,
		OP_TPA       = 5'd25,
		OP_BRANCH    = 5'd26
	} alu_op_t;

	typedef enum logic [COND_W-1:0] {
		COND_ALWAYS = 4'd0,
		COND_CC     = 4'd1,
		COND_CS     = 4'd2,
		COND_EQ     = 4'd3,
		COND_NE     = 4'd4,
		COND_GE     = 4'd5,
		COND_GT     = 4'd6,
		COND_HI     = 4'd7,
		COND_LE     = 4'd8,
		COND_LS     = 4'd9,
		COND_LT     = 4'd10,
		COND_MI     = 4'd11,
		COND_PL     = 4'd12,
		COND_VC     = 4'd13,
		COND_VS     = 4'd14
	} alu_cond_t;

	typedef enum logic [FSEL_W-1:0] {
		FSEL_C = 2'd0,
		FSEL_V = 2'd1,
		FSEL_I = 2'd2
	} alu_fsel_t;

	typedef struct packed {
		alu_op_t           op;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
		alu_cond_t         condition;
		alu_fsel_t         flag_select;
		logic              flag_value;
	} alu_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  result;
		logic [FLAGS_W-1:0] flags_out;
		logic               taken;
	} alu_res_t;

endpackage

`default_nettype wire

// File: rtl/alu_cc_core.sv
// Combinational ALU datapath: result, next condition codes and branch test.
`timescale 1ns / 1ps
`default_nettype none

module alu_cc_core (
	input  alu_cc_pkg::alu_item_t             item,
	input  logic [alu_cc_pkg::CC_W-1:0]       cc,
	output logic [alu_cc_pkg::CC_W-1:0]       cc_next,
	output alu_cc_pkg::alu_res_t              res
);
	import alu_cc_pkg::*;

	logic [BYTE_W-1:0] a8;
	logic [BYTE_W-1:0] b8;
	logic              c_in;
	logic              h_in;
	logic              daa_lo;
	logic              daa_hi;
	logic [BYTE_W-1:0] daa_incr;
	logic [BYTE_W-1:0] add_b;
	logic              add_c;
	logic [BYTE_W:0]   sum9;
	logic [4:0]        sum_lo5;
	logic              add_v;
	logic [BYTE_W-1:0] sub_b;
	logic              sub_c;
	logic [BYTE_W:0]   diff9;
	logic              sub_v;
	logic [BYTE_W-1:0] shift_r;
	logic              shift_co;
	logic [DATA_W-1:0] cmp_r;
	logic              cmp_v;
	logic              cond_true;
	logic [DATA_W-1:0] r;
	logic [CC_W-1:0]   nxt;
	logic              set_zn8;
	logic              set_zn16;
	logic              taken;

	assign a8   = item.operand_a[BYTE_W-1:0];
	assign b8   = item.operand_b[BYTE_W-1:0];
	assign c_in = cc[FLAG_C];
	assign h_in = cc[FLAG_H];

	assign daa_lo   = (a8[3:0] > BCD_DIGIT_MAX);
	assign daa_hi   = (a8 > BCD_BYTE_MAX);
	assign daa_incr = ((h_in || daa_lo) ? DAA_LO_ADJ : 8'h00)
		| ((c_in || daa_hi) ? DAA_HI_ADJ : 8'h00);

	always_comb begin
		priority if (item.op == OP_INC) begin
			add_b = 8'h01;
		end else if (item.op == OP_DAA) begin
			add_b = daa_incr;
		end else begin
			add_b = b8;
		end
	end

	assign add_c   = (item.op == OP_ADC) ? c_in : 1'b0;
	assign sum9    = {1'b0, a8} + {1'b0, add_b} + {8'd0, add_c};
	assign sum_lo5 = {1'b0, a8[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_c};
	assign add_v   = ~(a8[7] ^ add_b[7]) & (a8[7] ^ sum9[7]);

	assign sub_b = (item.op == OP_DEC) ? 8'h01 : b8;
	assign sub_c = (item.op == OP_SBC) ? c_in : 1'b0;
	assign diff9 = {1'b0, a8} - {1'b0, sub_b} - {8'd0, sub_c};
	assign sub_v = (a8[7] ^ sub_b[7]) & (a8[7] ^ diff9[7]);

	always_comb begin
		unique case (item.op)
			OP_LSR: begin
				shift_r  = {1'b0, a8[7:1]};
				shift_co = a8[0];
			end
			OP_ASR: begin
				shift_r  = {a8[7], a8[7:1]};
				shift_co = a8[0];
			end
			OP_ASL: begin
				shift_r  = {a8[6:0], 1'b0};
				shift_co = a8[7];
			end
			OP_ROR: begin
				shift_r  = {c_in, a8[7:1]};
				shift_co = a8[0];
			end
			default: begin
				shift_r  = {a8[6:0], c_in};
				shift_co = a8[7];
			end
		endcase
	end

	assign cmp_r = {item.operand_a[15:8] - item.operand_b[15:8], a8 - b8};
	assign cmp_v = (item.operand_a[15] ^ item.operand_b[15]) & (item.operand_a[15] ^ cmp_r[15]);

	always_comb begin
		unique case (item.condition)
			COND_ALWAYS: cond_true = 1'b1;
			COND_CC:     cond_true = ~cc[FLAG_C];
			COND_CS:     cond_true = cc[FLAG_C];
			COND_EQ:     cond_true = cc[FLAG_Z];
			COND_NE:     cond_true = ~cc[FLAG_Z];
			COND_GE:     cond_true = ~(cc[FLAG_N] ^ cc[FLAG_V]);
			COND_GT:     cond_true = ~cc[FLAG_Z] & ~(cc[FLAG_N] ^ cc[FLAG_V]);
			COND_HI:     cond_true = ~cc[FLAG_C] & ~cc[FLAG_Z];
			COND_LE:     cond_true = cc[FLAG_Z] | (cc[FLAG_N] ^ cc[FLAG_V]);
			COND_LS:     cond_true = cc[FLAG_C] | cc[FLAG_Z];
			COND_LT:     cond_true = cc[FLAG_N] ^ cc[FLAG_V];
			COND_MI:     cond_true = cc[FLAG_N];
			COND_PL:     cond_true = ~cc[FLAG_N];
			COND_VC:     cond_true = ~cc[FLAG_V];
			COND_VS:     cond_true = cc[FLAG_V];
			default:     cond_true = 1'b0;
		endcase
	end

	always_comb begin
		nxt      = cc;
		r        = '0;
		set_zn8  = 1'b0;
		set_zn16 = 1'b0;
		taken    = 1'b0;
		unique case (item.op)
			OP_ADD, OP_ADC: begin
				r           = {8'h00, sum9[7:0]};
				set_zn8     = 1'b1;
				nxt[FLAG_C] = sum9[8];
				nxt[FLAG_V] = add_v;
				nxt[FLAG_H] = sum_lo5[4];
			end
			OP_INC: begin
				r           = {8'h00, sum9[7:0]};
				set_zn8     = 1'b1;
				nxt[FLAG_V] = add_v;
			end
			OP_DAA: begin
				r           = {8'h00, sum9[7:0]};
				set_zn8     = 1'b1;
				nxt[FLAG_V] = add_v;
				nxt[FLAG_C] = c_in | daa_hi;
			end
			OP_SUB, OP_SBC: begin
				r           = {8'h00, diff9[7:0]};
				set_zn8     = 1'b1;
				nxt[FLAG_C] = diff9[8];
				nxt[FLAG_V] = sub_v;
			end
			OP_DEC: begin
				r           = {8'h00, diff9[7:0]};
				set_zn8     = 1'b1;
				nxt[FLAG_V] = sub_v;
			end
			OP_AND: begin
				r           = {8'h00, a8 & b8};
				set_zn8     = 1'b1;
				nxt[FLAG_V] = 1'b0;
			end
			OP_OR: begin
				r           = {8'h00, a8 | b8};
				set_zn8     = 1'b1;
				nxt[FLAG_V] = 1'b0;
			end
			OP_EOR: begin
				r           = {8'h00, a8 ^ b8};
				set_zn8     = 1'b1;
				nxt[FLAG_V] = 1'b0;
			end
			OP_PASS: begin
				r           = {8'h00, a8};
				set_zn8     = 1'b1;
				nxt[FLAG_V] = 1'b0;
			end
			OP_TST: begin
				r           = {8'h00, a8};
				set_zn8     = 1'b1;
				nxt[FLAG_C] = 1'b0;
				nxt[FLAG_V] = 1'b0;
			end
			OP_CLR: begin
				nxt[FLAG_C] = 1'b0;
				nxt[FLAG_V] = 1'b0;
				nxt[FLAG_N] = 1'b0;
				nxt[FLAG_Z] = 1'b1;
			end
			OP_COM: begin
				r           = {8'h00, ~a8};
				set_zn8     = 1'b1;
				nxt[FLAG_C] = 1'b1;
				nxt[FLAG_V] = 1'b0;
			end
			OP_LSR, OP_ASR, OP_ASL, OP_ROR, OP_ROL: begin
				r           = {8'h00, shift_r};
				set_zn8     = 1'b1;
				nxt[FLAG_C] = shift_co;
				nxt[FLAG_V] = shift_co ^ shift_r[7];
			end
			OP_CMP16: begin
				r           = cmp_r;
				set_zn16    = 1'b1;
				nxt[FLAG_V] = cmp_v;
			end
			OP_PASS16: begin
				r           = item.operand_a;
				set_zn16    = 1'b1;
				nxt[FLAG_V] = 1'b0;
			end
			OP_INC16: begin
				r           = item.operand_a + 16'd1;
				nxt[FLAG_Z] = (item.operand_a == 16'hffff);
			end
			OP_DEC16: begin
				r           = item.operand_a - 16'd1;
				nxt[FLAG_Z] = (item.operand_a == 16'h0001);
			end
			OP_FLAGWRITE: begin
				unique case (item.flag_select)
					FSEL_C:  nxt[FLAG_C] = item.flag_value;
					FSEL_V:  nxt[FLAG_V] = item.flag_value;
					FSEL_I:  nxt[FLAG_I] = item.flag_value;
					default: ;
				endcase
			end
			OP_TAP: begin
				nxt = item.operand_a[CC_W-1:0];
			end
			OP_TPA: begin
				r = {8'h00, FLAG_PAD, cc};
			end
			OP_BRANCH: begin
				taken = cond_true;
			end
			default: ;
		endcase
		if (set_zn8) begin
			nxt[FLAG_Z] = (r[7:0] == 8'h00);
			nxt[FLAG_N] = r[7];
		end
		if (set_zn16) begin
			nxt[FLAG_Z] = (r == 16'h0000);
			nxt[FLAG_N] = r[15];
		end
	end

	assign cc_next       = nxt;
	assign res.result    = r;
	assign res.flags_out = {FLAG_PAD, nxt};
	assign res.taken     = taken;

endmodule

`default_nettype wire

// File: rtl/alu_condition_code_unit.sv
// Top level of the 8-bit ALU with condition codes: input and result registers.
//
//   channel  dir  fields (tdata, lowest bit first)
//   s_axis   in   op[4:0] operand_a[20:5] operand_b[36:21] condition[40:37]
//                 flag_select[42:41] flag_value[43], zero fill to 48 bits
//   m_axis   out  result[15:0] flags_out[23:16] taken[24], zero fill to 32 bits
//
// One word per cycle sustained unless the output stalls; the result is registered.
// The condition code register updates as a word moves from the input register
// to the result register, so the next word sees the flags of the one before.
// Reset clears the flags and empties both registers.
// A stalled result holds; the input register takes one more word, then ready drops.
`timescale 1ns / 1ps
`default_nettype none

module alu_condition_code_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// op, operand_a, operand_b, condition, flag_select, flag_value
	input  logic [alu_cc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// result, flags_out, taken
	output logic [alu_cc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
	import alu_cc_pkg::*;

	alu_item_t       item_in;
	alu_item_t       item_s1;
	logic            valid_s1;
	alu_res_t        res_next;
	alu_res_t        res_s2;
	logic            valid_s2;
	logic [CC_W-1:0] cc_q;
	logic [CC_W-1:0] cc_next;
	logic            advance;

	assign item_in.op          = alu_op_t'(s_axis_tdata[4:0]);
	assign item_in.operand_a   = s_axis_tdata[20:5];
	assign item_in.operand_b   = s_axis_tdata[36:21];
	assign item_in.condition   = alu_cond_t'(s_axis_tdata[40:37]);
	assign item_in.flag_select = alu_fsel_t'(s_axis_tdata[42:41]);
	assign item_in.flag_value  = s_axis_tdata[43];

	assign advance       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	alu_cc_core u_core (
		.item    (item_s1),
		.cc      (cc_q),
		.cc_next (cc_next),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cc_q     <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				cc_q     <= cc_next;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, res_s2.taken, res_s2.flags_out, res_s2.result};

endmodule

`default_nettype wire

// File: rtl/alu_cc_checker.sv
// Port checker of the ALU condition code unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "alu_condition_code_unit_assert.svh"

module alu_cc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic [alu_cc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [alu_cc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
	import alu_cc_pkg::*;

	logic s_acc;
	logic s_data_seen;

	assign s_acc       = s_axis_tvalid & s_axis_tready;
	assign s_data_seen = ^s_axis_tdata | 1'b1;

	`ACC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`ACC_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid && s_data_seen, s_axis_tready)
	`ACC_ASSERT_NXT(a_word_flows, $past(s_acc) && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)
	`ACC_ASSERT_NOW(a_taken_no_result, m_axis_tvalid && m_axis_tdata[24], m_axis_tdata[15:0] == 16'h0000)
	`ACC_ASSERT_NOW(a_flag_pad, m_axis_tvalid, m_axis_tdata[23:22] == FLAG_PAD)

endmodule

bind alu_condition_code_unit alu_cc_checker u_alu_cc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
